// ----- hdl/rawd_pkg.sv -----
// ----------------------------------------------------------------------------
// rawd_pkg
// Shared types, sizes and codes of the radar activity window decider.
// ----------------------------------------------------------------------------
package rawd_pkg;

  // Window geometry
  localparam int WINDOW_LEN   = 32;
  localparam int TARGET_COUNT = 3;
  localparam int NUM_SCORES   = 5;
  localparam int STORE_DEPTH  = TARGET_COUNT * WINDOW_LEN;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int POS_W        = $clog2(WINDOW_LEN);

  // One stored entry: velocity, x, y
  localparam int ENTRY_W      = 48;

  // Config port
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;

  // Config reset values
  localparam logic [14:0] VELOCITY_LIMIT_RST = 15'd1000;
  localparam logic [15:0] CONFIDENCE_RST     = 16'd32768;
  localparam logic [15:0] JUMP_LIMIT_RST     = 16'd155;
  localparam logic [15:0] STILL_THRESH_RST   = 16'd15;
  localparam logic [4:0]  STILL_MASK_RST     = 5'd20;
  localparam logic        SKIP_MOTION_RST    = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_ANALYSE = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_READ    = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    RES_STORED        = 3'd0,
    RES_VEL_DROPPED   = 3'd1,
    RES_FULL_IGNORED  = 3'd2,
    RES_ACCEPTED      = 3'd3,
    RES_LOW_CONF      = 3'd4,
    RES_MOTION_FAILED = 3'd5,
    RES_RESTARTED     = 3'd6,
    RES_READ          = 3'd7
  } res_code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VELOCITY_LIMIT = 3'd0,
    CFG_CONFIDENCE     = 3'd1,
    CFG_JUMP_LIMIT     = 3'd2,
    CFG_STILL_THRESH   = 3'd3,
    CFG_STILL_MASK     = 3'd4,
    CFG_SKIP_MOTION    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    command_t           command;
    logic [1:0]         target;
    logic signed [15:0] sample_velocity;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic [4:0]         entry_index;
    logic [15:0]        score_0;
    logic [15:0]        score_1;
    logic [15:0]        score_2;
    logic [15:0]        score_3;
    logic [15:0]        score_4;
  } in_item_t;

  typedef struct packed {
    res_code_t          result_code;
    logic [2:0]         action_class;
    logic               window_full;
    logic [4:0]         fill_count;
    logic signed [15:0] read_velocity;
    logic signed [15:0] read_x;
    logic signed [15:0] read_y;
  } out_item_t;

  typedef struct packed {
    logic [14:0] velocity_limit;
    logic [15:0] confidence_threshold;
    logic [15:0] jump_limit;
    logic [15:0] still_threshold;
    logic [4:0]  still_class_mask;
    logic        skip_motion_check;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the input word
    logic exec;     // run the command's single-cycle part
    logic walk_rd;  // read next window entry of the walk
    logic finish;   // load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    command_t command;
    logic     walk_last;
  } dp_status_t;

endpackage

// ----- hdl/radar_activity_window_decider.sv -----
// ----------------------------------------------------------------------------
// radar_activity_window_decider
// Collects radar target samples into a shared-index window and judges a
// classifier's answer by confidence and by target movement in the window.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload            | direction
//  ---------+---------------------+--------------------+----------
//  command  | start / busy        | item   (in_item_t) | in
//  result   | done (1-cycle)      | result (out_item_t)| out
//  config   | cfg_write           | cfg_index,cfg_data | in
//
//  Sequence: add, restart and read go through the execute state and the
//  finish state; busy is high over both and the next word may be accepted
//  in the done cycle. Analyse is busy from the execute state to the finish
//  state: the execute state, the walk over the window through the single
//  read port of the sample store, one coordinate pair per cycle, the drain
//  states DRAIN1 and DRAIN2 of the step check, and the finish state.
//  Reset: synchronous; config returns to defaults, window empty at once
//  (per-entry valid bits, no clearing pass).
//  Stalls: the receiver cannot stall; done is a one-cycle strobe and the
//  result word is valid in that cycle only.
// ----------------------------------------------------------------------------
module radar_activity_window_decider (
  input  logic                             clk,
  input  logic                             rst,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  rawd_pkg::in_item_t               item,
  // result channel
  output logic                             done,
  output rawd_pkg::out_item_t              result,
  // config write port
  input  logic                             cfg_write,
  input  logic [rawd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rawd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rawd_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // config registers, held until rewritten
  rawd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: one word at a time
  rawd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // store, fill state, argmax, step check, result register
  rawd_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (result)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------

  // an accepted word always holds the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // the winning class is always a real class
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(result.action_class) < NUM_SCORES))
    else $error("action class out of range");

  // a restart leaves an empty window
  a_restart_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (result.result_code == RES_RESTARTED)) |->
      (!result.window_full && (result.fill_count == '0)))
    else $error("restart did not empty the window");

endmodule

// ----- hdl/rawd_ram.sv -----
// ----------------------------------------------------------------------------
// rawd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rawd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/rawd_regs.sv -----
// ----------------------------------------------------------------------------
// rawd_regs
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module rawd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rawd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rawd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rawd_pkg::cfg_t                  cfg
);

  import rawd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.velocity_limit       <= VELOCITY_LIMIT_RST;
      cfg.confidence_threshold <= CONFIDENCE_RST;
      cfg.jump_limit           <= JUMP_LIMIT_RST;
      cfg.still_threshold      <= STILL_THRESH_RST;
      cfg.still_class_mask     <= STILL_MASK_RST;
      cfg.skip_motion_check    <= SKIP_MOTION_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VELOCITY_LIMIT: cfg.velocity_limit       <= cfg_data[14:0];
        CFG_CONFIDENCE:     cfg.confidence_threshold <= cfg_data;
        CFG_JUMP_LIMIT:     cfg.jump_limit           <= cfg_data;
        CFG_STILL_THRESH:   cfg.still_threshold      <= cfg_data;
        CFG_STILL_MASK:     cfg.still_class_mask     <= cfg_data[4:0];
        CFG_SKIP_MOTION:    cfg.skip_motion_check    <= cfg_data[0];
        default: ;  // unused index, dropped
      endcase
    end
  end

endmodule

// ----- hdl/rawd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rawd_ctrl
// Sequencer: accept, execute, window walk with pipeline drain, finish.
// ----------------------------------------------------------------------------
module rawd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output rawd_pkg::ctrl_cmd_t  cmd,
  input  rawd_pkg::dp_status_t status
);

  import rawd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DRAIN1,
    S_DRAIN2,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= (status.command == CMD_ANALYSE) ? S_WALK : S_FINISH;
        end
        S_WALK: begin
          if (status.walk_last) begin
            state <= S_DRAIN1;
          end
        end
        S_DRAIN1: state <= S_DRAIN2;   // read data -> step deltas
        S_DRAIN2: state <= S_FINISH;   // deltas -> still flag
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load    = start && (state == S_IDLE);
    cmd.exec    = (state == S_EXEC);
    cmd.walk_rd = (state == S_WALK);
    cmd.finish  = (state == S_FINISH);
  end

endmodule

// ----- hdl/rawd_dp.sv -----
// ----------------------------------------------------------------------------
// rawd_dp
// Datapath: window store with valid bits, fill state, argmax, step check
// pipeline and result register.
// ----------------------------------------------------------------------------
module rawd_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  rawd_pkg::in_item_t    item,
  input  rawd_pkg::cfg_t        cfg,
  input  rawd_pkg::ctrl_cmd_t   cmd,
  output rawd_pkg::dp_status_t  status,
  output logic                  done,
  output rawd_pkg::out_item_t   result
);

  import rawd_pkg::*;

  // |a - b| of two signed 16-bit values, exact (fits 16 bits unsigned)
  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d[16] ? 16'(-d) : d[15:0];
  endfunction

  in_item_t            item_q;

  logic [POS_W-1:0]    fill_index;
  logic                full_flag;
  logic [STORE_DEPTH-1:0] valid;

  res_code_t           code_q;
  logic [2:0]          cls_q;
  logic [15:0]         best_q;

  logic [POS_W-1:0]    walk_idx;
  logic                rd_active;
  logic                rd_first;
  logic                rd_ok;
  logic signed [15:0]  prev_x;
  logic signed [15:0]  prev_y;
  logic [15:0]         dx_q;
  logic [15:0]         dy_q;
  logic                step_valid;
  logic                still_seen;

  // RAM side
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [ADDR_W-1:0]   base_addr;
  logic [ADDR_W-1:0]   fill_addr;
  logic [ADDR_W-1:0]   read_addr;
  logic [ADDR_W-1:0]   walk_addr;
  logic                target_ok;
  logic                read_ok;
  logic                walk_ok;

  logic signed [16:0]  vel_ext;
  logic [16:0]         vel_mag;
  logic                vel_ok;
  logic                add_ok;
  logic                fill_wrap;

  logic [15:0]         scores [NUM_SCORES];
  logic [15:0]         best;
  logic [2:0]          best_cls;

  logic [ENTRY_W-1:0]  ent;
  logic signed [15:0]  ent_v;
  logic signed [15:0]  ent_x;
  logic signed [15:0]  ent_y;

  logic                step_jump;
  logic [15:0]         step_max;
  res_code_t           analyse_code;

  // --- addressing ---
  assign target_ok = (int'(item_q.target) < TARGET_COUNT);
  assign base_addr = ADDR_W'(item_q.target) * ADDR_W'(WINDOW_LEN);
  assign fill_addr = base_addr + ADDR_W'(fill_index);
  assign read_addr = base_addr + ADDR_W'(item_q.entry_index);
  assign walk_addr = base_addr + ADDR_W'(walk_idx);

  // an entry never written since reset/restart reads as zero
  assign read_ok = target_ok && (int'(item_q.entry_index) < WINDOW_LEN) && valid[read_addr];
  assign walk_ok = target_ok && valid[walk_addr];

  // --- add path ---
  assign vel_ext   = 17'(item_q.sample_velocity);
  assign vel_mag   = vel_ext[16] ? 17'(-vel_ext) : 17'(vel_ext);
  assign vel_ok    = (vel_mag <= {2'b00, cfg.velocity_limit});
  assign add_ok    = !full_flag && target_ok && vel_ok;
  assign fill_wrap = (fill_index == POS_W'(WINDOW_LEN - 1));

  assign ram_we    = cmd.exec && (item_q.command == CMD_ADD) && add_ok;
  assign ram_wdata = {item_q.sample_velocity, item_q.sample_x, item_q.sample_y};
  assign ram_re    = cmd.walk_rd || (cmd.exec && (item_q.command == CMD_READ));
  assign ram_raddr = cmd.walk_rd ? walk_addr : read_addr;

  rawd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent   = rd_ok ? ram_rdata : '0;
  assign ent_v = ent[47:32];
  assign ent_x = ent[31:16];
  assign ent_y = ent[15:0];

  // --- argmax, ties keep the lower class ---
  assign scores[0] = item_q.score_0;
  assign scores[1] = item_q.score_1;
  assign scores[2] = item_q.score_2;
  assign scores[3] = item_q.score_3;
  assign scores[4] = item_q.score_4;

  always_comb begin
    best     = scores[0];
    best_cls = '0;
    for (int k = 1; k < NUM_SCORES; k++) begin
      if (scores[k] > best) begin
        best     = scores[k];
        best_cls = 3'(k);
      end
    end
  end

  // --- step check ---
  assign step_jump = (dx_q > cfg.jump_limit) || (dy_q > cfg.jump_limit);
  assign step_max  = (dx_q > dy_q) ? dx_q : dy_q;

  always_comb begin
    if (best_q < cfg.confidence_threshold) begin
      analyse_code = RES_LOW_CONF;
    end else if (cfg.skip_motion_check) begin
      analyse_code = RES_ACCEPTED;
    end else if (cfg.still_class_mask[cls_q] && still_seen) begin
      analyse_code = RES_MOTION_FAILED;
    end else begin
      analyse_code = RES_ACCEPTED;
    end
  end

  assign status.command   = item_q.command;
  assign status.walk_last = (walk_idx == POS_W'(WINDOW_LEN - 1));

  // --- control state ---
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index <= '0;
      full_flag  <= 1'b0;
      valid      <= '0;
      walk_idx   <= '0;
      rd_active  <= 1'b0;
      step_valid <= 1'b0;
      still_seen <= 1'b0;
      done       <= 1'b0;
    end else begin
      rd_active  <= cmd.walk_rd;
      step_valid <= rd_active && !rd_first;
      done       <= cmd.finish;

      if (cmd.exec) begin
        unique case (item_q.command)
          CMD_ADD: begin
            if (add_ok) begin
              valid[fill_addr] <= 1'b1;
              if (fill_wrap) begin
                fill_index <= '0;
                full_flag  <= 1'b1;
              end else begin
                fill_index <= fill_index + 1'b1;
              end
            end
          end
          CMD_ANALYSE: begin
            walk_idx   <= '0;
            still_seen <= 1'b0;
          end
          CMD_RESTART: begin
            valid      <= '0;
            fill_index <= '0;
            full_flag  <= 1'b0;
          end
          CMD_READ: ;
          default: ;
        endcase
      end

      if (cmd.walk_rd) begin
        walk_idx <= walk_idx + 1'b1;
      end

      if (step_valid && !step_jump && (step_max < cfg.still_threshold)) begin
        still_seen <= 1'b1;
      end
    end
  end

  // --- payload ---
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end

    if (cmd.exec) begin
      best_q <= best;
      cls_q  <= best_cls;
      unique case (item_q.command)
        CMD_ADD: begin
          if (full_flag) begin
            code_q <= RES_FULL_IGNORED;
          end else if (!target_ok || !vel_ok) begin
            code_q <= RES_VEL_DROPPED;
          end else begin
            code_q <= RES_STORED;
          end
        end
        CMD_ANALYSE: code_q <= RES_ACCEPTED;
        CMD_RESTART: code_q <= RES_RESTARTED;
        CMD_READ:    code_q <= RES_READ;
        default:     code_q <= RES_READ;
      endcase
    end

    if (ram_re) begin
      rd_first <= (walk_idx == '0);
      rd_ok    <= cmd.walk_rd ? walk_ok : read_ok;
    end

    if (rd_active) begin
      dx_q   <= abs_diff(ent_x, prev_x);
      dy_q   <= abs_diff(ent_y, prev_y);
      prev_x <= ent_x;
      prev_y <= ent_y;
    end

    if (cmd.finish) begin
      result.window_full <= full_flag;
      result.fill_count  <= 5'(fill_index);
      if (item_q.command == CMD_ANALYSE) begin
        result.result_code  <= analyse_code;
        result.action_class <= cls_q;
      end else begin
        result.result_code  <= code_q;
        result.action_class <= '0;
      end
      if (item_q.command == CMD_READ) begin
        result.read_velocity <= ent_v;
        result.read_x        <= ent_x;
        result.read_y        <= ent_y;
      end else begin
        result.read_velocity <= '0;
        result.read_x        <= '0;
        result.read_y        <= '0;
      end
    end
  end

endmodule
